/* rtl/core/rpn_pkg.sv */
// Package of the RPN stack evaluator: item structs, opcode and status codes,
// controller states and the command and status groups. No dependencies.
package rpn_pkg;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_SUB    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_DIV    = 3'd4;
    localparam logic [2:0] OP_FINISH = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE = 3'd2;
    localparam logic [2:0] ST_DIVZERO    = 3'd3;
    localparam logic [2:0] ST_INVALID    = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic               result_valid;
        logic [7:0]         depth;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPER,
        S_MULSAT,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       clear;
        logic       rd;
        logic       mul_cap;
        logic       div_start;
        logic       pop_write;
        logic       emit;
        logic [2:0] status;
        logic       vzero;
        logic       final_res;
    } t_cmd;

    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       cnt_one;
        logic       cnt_ge2;
        logic       top_zero;
        logic       div_done;
    } t_stat;

endpackage

/* rtl/core/rpn_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/rpn_div.sv */
// Radix-2 restoring divider for (A * 65536) / B on magnitudes, one quotient
// bit per cycle. No dependencies.
module rpn_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_dividend,
    input  logic signed [31:0] i_divisor,
    output logic               o_done,
    output logic [47:0]        o_mag,
    output logic               o_neg
);

    localparam int QW  = 48;
    localparam int CNW = $clog2(QW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [32:0]    r_rem;
    logic [QW-1:0]  r_quo;
    logic [31:0]    r_den;
    logic           r_neg;

    logic [31:0] w_mag_a;
    logic [31:0] w_mag_b;
    logic [32:0] w_rem_sh;
    logic [33:0] w_diff;

    assign w_mag_a  = i_dividend[31] ? 32'(-i_dividend) : i_dividend;
    assign w_mag_b  = i_divisor[31] ? 32'(-i_divisor) : i_divisor;
    assign w_rem_sh = {r_rem[31:0], r_quo[QW-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {w_mag_a, 16'd0};
            r_den <= w_mag_b;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                r_rem <= w_diff[32:0];
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_quo;
    assign o_neg  = r_neg;

endmodule

/* rtl/core/rpn_datapath.sv */
// Datapath of the RPN evaluator: cached top of stack, entry count, stack RAM,
// add/subtract/multiply with saturation, divider and result register.
// Depends on rpn_pkg, rpn_ram and rpn_div.
module rpn_datapath #(
    parameter int STACK_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpn_pkg::t_in_item  i_item,
    input  rpn_pkg::t_cmd      i_cmd,
    output rpn_pkg::t_stat     o_stat,
    output logic               o_valid,
    output rpn_pkg::t_out_item o_result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic signed [48:0] SAT_HI = 49'sh0_0000_7FFF_FFFF;
    localparam logic signed [48:0] SAT_LO = 49'sh1_FFFF_8000_0000;

    function automatic logic [31:0] sat32(input logic signed [48:0] v);
        logic [31:0] res;
        if (v > SAT_HI) begin
            res = 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic [2:0]         r_op;
    logic signed [31:0] r_operand;
    logic signed [31:0] r_top;
    logic [CW-1:0]      r_count;
    logic signed [63:0] r_prod;
    logic               r_valid;
    rpn_pkg::t_out_item r_res;

    logic [31:0]        w_rdata;
    logic signed [31:0] w_second;
    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_cnt_m2;
    logic               w_we;
    logic signed [48:0] w_a49;
    logic signed [48:0] w_b49;
    logic signed [48:0] w_sum;
    logic signed [48:0] w_dif;
    logic signed [48:0] w_mulq;
    logic               w_rnd;
    logic               w_div_done;
    logic [47:0]        w_div_mag;
    logic               w_div_neg;
    logic signed [48:0] w_divq;
    logic [31:0]        w_arith;
    logic [CW+7:0]      w_cnt_ext;

    assign w_cnt_m1 = r_count - 1'b1;
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_we     = i_cmd.push && (r_count != '0);
    assign w_second = $signed(w_rdata);

    rpn_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_cnt_m1[AW-1:0]),
        .i_wdata(r_top),
        .i_re   (i_cmd.rd),
        .i_raddr(w_cnt_m2[AW-1:0]),
        .o_rdata(w_rdata)
    );

    rpn_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(w_second),
        .i_divisor (r_top),
        .o_done    (w_div_done),
        .o_mag     (w_div_mag),
        .o_neg     (w_div_neg)
    );

    assign w_a49  = {{17{w_second[31]}}, w_second};
    assign w_b49  = {{17{r_top[31]}}, r_top};
    assign w_sum  = w_a49 + w_b49;
    assign w_dif  = w_a49 - w_b49;
    assign w_rnd  = r_prod[63] && (r_prod[15:0] != 16'd0);
    assign w_mulq = {r_prod[63], r_prod[63:16]} + {48'd0, w_rnd};
    assign w_divq = w_div_neg ? (49'sd0 - $signed({1'b0, w_div_mag}))
                              : $signed({1'b0, w_div_mag});

    always_comb begin
        case (r_op)
            rpn_pkg::OP_ADD: w_arith = sat32(w_sum);
            rpn_pkg::OP_SUB: w_arith = sat32(w_dif);
            rpn_pkg::OP_MUL: w_arith = sat32(w_mulq);
            rpn_pkg::OP_DIV: w_arith = sat32(w_divq);
            default:         w_arith = sat32(w_sum);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_write) begin
                r_count <= w_cnt_m1;
            end
        end
    end

    assign w_cnt_ext = {8'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_item.opcode;
            r_operand <= i_item.operand;
        end
        if (i_cmd.push) begin
            r_top <= r_operand;
        end else if (i_cmd.pop_write) begin
            r_top <= $signed(w_arith);
        end
        if (i_cmd.mul_cap) begin
            r_prod <= w_second * r_top;
        end
        if (i_cmd.emit) begin
            r_res.status       <= i_cmd.status;
            r_res.value        <= i_cmd.vzero ? 32'sd0 : r_top;
            r_res.result_valid <= i_cmd.final_res;
            r_res.depth        <= w_cnt_ext[7:0];
        end
    end

    assign o_stat.opcode   = r_op;
    assign o_stat.full     = (r_count == CW'(STACK_DEPTH));
    assign o_stat.cnt_one  = (r_count == CW'(1));
    assign o_stat.cnt_ge2  = (r_count >= CW'(2));
    assign o_stat.top_zero = (r_top == 32'sd0);
    assign o_stat.div_done = w_div_done;
    assign o_valid         = r_valid;
    assign o_result        = r_res;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count exceeds the stack depth");
`endif

endmodule

/* rtl/core/rpn_ctrl.sv */
// Controller of the RPN evaluator: decodes each item against the stack
// state and sequences the datapath. Depends on rpn_pkg.
module rpn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rpn_pkg::t_stat i_stat,
    output logic           o_busy,
    output rpn_pkg::t_cmd  o_cmd
);

    rpn_pkg::t_state r_state;
    rpn_pkg::t_state n_state;
    logic [2:0]      r_status;
    logic [2:0]      n_status;
    logic            r_vzero;
    logic            n_vzero;
    logic            r_final;
    logic            n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rpn_pkg::S_DECODE) begin
            r_status <= n_status;
            r_vzero  <= n_vzero;
            r_final  <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpn_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = rpn_pkg::S_DECODE;
                end
            end
            rpn_pkg::S_DECODE: begin
                n_state = rpn_pkg::S_EMIT;
                if (i_stat.opcode != rpn_pkg::OP_PUSH && i_stat.opcode != rpn_pkg::OP_FINISH
                    && i_stat.cnt_ge2
                    && i_stat.opcode inside {rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
                                             rpn_pkg::OP_MUL, rpn_pkg::OP_DIV}
                    && !(i_stat.opcode == rpn_pkg::OP_DIV && i_stat.top_zero)) begin
                    n_state = rpn_pkg::S_OPER;
                end
            end
            rpn_pkg::S_OPER: begin
                case (i_stat.opcode)
                    rpn_pkg::OP_MUL: n_state = rpn_pkg::S_MULSAT;
                    rpn_pkg::OP_DIV: n_state = rpn_pkg::S_DIV;
                    default:         n_state = rpn_pkg::S_EMIT;
                endcase
            end
            rpn_pkg::S_MULSAT: n_state = rpn_pkg::S_EMIT;
            rpn_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = rpn_pkg::S_EMIT;
                end
            end
            rpn_pkg::S_EMIT: n_state = rpn_pkg::S_IDLE;
            default:         n_state = rpn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.status    = r_status;
        o_cmd.vzero     = r_vzero;
        o_cmd.final_res = r_final;
        n_status        = rpn_pkg::ST_OK;
        n_vzero         = 1'b0;
        n_final         = 1'b0;
        case (r_state)
            rpn_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            rpn_pkg::S_DECODE: begin
                case (i_stat.opcode)
                    rpn_pkg::OP_PUSH: begin
                        if (i_stat.full) begin
                            n_status = rpn_pkg::ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    rpn_pkg::OP_FINISH: begin
                        o_cmd.clear = 1'b1;
                        if (i_stat.cnt_one) begin
                            n_final = 1'b1;
                        end else begin
                            n_status = rpn_pkg::ST_INCOMPLETE;
                            n_vzero  = 1'b1;
                        end
                    end
                    default: begin
                        if (!i_stat.cnt_ge2) begin
                            o_cmd.clear = 1'b1;
                            n_status    = rpn_pkg::ST_INCOMPLETE;
                            n_vzero     = 1'b1;
                        end else if (i_stat.opcode inside {rpn_pkg::OP_ADD, rpn_pkg::OP_SUB,
                                                           rpn_pkg::OP_MUL, rpn_pkg::OP_DIV}) begin
                            if (i_stat.opcode == rpn_pkg::OP_DIV && i_stat.top_zero) begin
                                o_cmd.clear = 1'b1;
                                n_status    = rpn_pkg::ST_DIVZERO;
                                n_vzero     = 1'b1;
                            end else begin
                                o_cmd.rd = 1'b1;
                            end
                        end else begin
                            o_cmd.clear = 1'b1;
                            n_status    = rpn_pkg::ST_INVALID;
                            n_vzero     = 1'b1;
                        end
                    end
                endcase
            end
            rpn_pkg::S_OPER: begin
                case (i_stat.opcode)
                    rpn_pkg::OP_MUL: o_cmd.mul_cap   = 1'b1;
                    rpn_pkg::OP_DIV: o_cmd.div_start = 1'b1;
                    default:         o_cmd.pop_write = 1'b1;
                endcase
            end
            rpn_pkg::S_MULSAT: o_cmd.pop_write = 1'b1;
            rpn_pkg::S_DIV:    o_cmd.pop_write = i_stat.div_done;
            rpn_pkg::S_EMIT:   o_cmd.emit      = 1'b1;
            default: ;
        endcase
    end

    assign o_busy = (r_state != rpn_pkg::S_IDLE);

`ifndef SYNTH
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::S_OPER && i_stat.opcode == rpn_pkg::OP_DIV)
        |=> (r_state == rpn_pkg::S_DIV && !i_stat.div_done))
        else $error("divider finished without a full iteration");
`endif

endmodule

/* rtl/core/rpn_stack_evaluator_unit.sv */
// Top level of the RPN stack evaluator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_datapath.
//
// An item is taken at a rising edge with start high and busy low; busy stays
// high until the item's single result has been registered. The result is
// shown on o_result for exactly one cycle with o_valid high and cannot be
// held off; a new item may be started in that same cycle. Push, finish and
// every error go from decode straight to emit; add and subtract first
// do one registered read of the stack RAM for the second entry, multiply
// also registers the product before rounding and saturation, and divide
// waits for the 48-step radix-2 divider producing one quotient bit a cycle.
// The top of stack is held in a register, so the stack RAM of STACK_DEPTH
// words needs no clearing after reset.
module rpn_stack_evaluator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rpn_pkg::t_in_item  i_item,
    output logic               o_valid,
    output rpn_pkg::t_out_item o_result
);

    rpn_pkg::t_cmd  w_cmd;
    rpn_pkg::t_stat w_stat;

    rpn_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (w_stat),
        .o_busy (busy),
        .o_cmd  (w_cmd)
    );

    rpn_datapath #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .o_result(o_result)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");
    a_final_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.result_valid)
        |-> (o_result.depth == 8'd0 && o_result.status == rpn_pkg::ST_OK))
        else $error("final result with a non-empty stack");
    a_error_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != rpn_pkg::ST_OK
                 && o_result.status != rpn_pkg::ST_FULL)
        |-> (o_result.depth == 8'd0 && o_result.value == 32'sd0
             && !o_result.result_valid))
        else $error("error result without a cleared stack");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for rpn_stack_evaluator_unit: directed and random item
// streams, every result checked against a stack predictor held in a scoreboard.
// Depends on rpn_pkg and the RTL of rpn_stack_evaluator_unit.
module tb_top;
    import rpn_pkg::*;

    localparam int         STACK_DEPTH = 128;
    localparam logic [2:0] OP_BAD6     = 3'd6;
    localparam logic [2:0] OP_BAD7     = 3'd7;
    localparam longint     Q_MAX       = 64'sd2147483647;
    localparam longint     Q_MIN       = -64'sd2147483648;

    class rpn_scoreboard;
        logic [31:0] stack_mem [STACK_DEPTH];
        int          entries;
        t_out_item   expected_results [$];
        int          errors;
        int          checked;
        int          finals;

        function new();
            entries = 0;
            errors = 0;
            checked = 0;
            finals = 0;
        endfunction

        function void record_item(t_in_item it);
            t_out_item r;
            longint    a;
            longint    b;
            longint    q;
            r = '0;
            if (it.opcode == OP_PUSH) begin
                if (entries >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                    r.value = stack_mem[entries - 1];
                end else begin
                    stack_mem[entries] = it.operand;
                    entries++;
                    r.value = it.operand;
                end
            end else if (it.opcode == OP_FINISH) begin
                if (entries == 1) begin
                    r.value = stack_mem[0];
                    r.result_valid = 1'b1;
                end else begin
                    r.status = ST_INCOMPLETE;
                end
                entries = 0;
            end else if (entries < 2) begin
                r.status = ST_INCOMPLETE;
                entries = 0;
            end else begin
                a = $signed(stack_mem[entries - 2]);
                b = $signed(stack_mem[entries - 1]);
                q = 0;
                case (it.opcode)
                    OP_ADD: q = a + b;
                    OP_SUB: q = a - b;
                    OP_MUL: q = (a * b) / 65536;
                    OP_DIV: begin
                        if (b == 0) r.status = ST_DIVZERO;
                        else q = (a * 65536) / b;
                    end
                    default: r.status = ST_INVALID;
                endcase
                if (r.status != ST_OK) begin
                    entries = 0;
                end else begin
                    if (q > Q_MAX) q = Q_MAX;
                    else if (q < Q_MIN) q = Q_MIN;
                    entries--;
                    stack_mem[entries - 1] = q[31:0];
                    r.value = q[31:0];
                end
            end
            r.depth = entries[7:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_results.size() == 0) begin
                if (errors < 10)
                    $display("Result with no item outstanding: status %0d value %h valid %b depth %0d",
                             got.status, got.value, got.result_valid, got.depth);
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            checked++;
            if (got.result_valid === 1'b1) finals++;
            if (got.status !== exp.status || got.value !== exp.value ||
                got.result_valid !== exp.result_valid || got.depth !== exp.depth) begin
                if (errors < 10)
                    $display("Mismatch at %0t: expected status %0d value %h valid %b depth %0d, got status %0d value %h valid %b depth %0d",
                             $time, exp.status, exp.value, exp.result_valid, exp.depth,
                             got.status, got.value, got.result_valid, got.depth);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_valid;
    t_in_item  i_item;
    t_out_item o_result;

    rpn_scoreboard sb;
    int            items_sent;
    int            fills;
    int            burst_left;
    int            kind;
    int            op_count [8];

    rpn_stack_evaluator_unit #(.STACK_DEPTH(STACK_DEPTH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result);
    end

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0, 1: v = $urandom;
            2: v = 32'h7fff_ffff;
            3: v = 32'h8000_0000;
            4: v = '0;
            5, 6: v = ($urandom_range(0, 40) - 20) << 16;
            default: begin
                v = $urandom_range(0, 32'h1ffff);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // Start stays high within a burst; a gap follows once the burst is used up.
    task automatic send(input logic [2:0] op, input logic [31:0] opd);
        t_in_item it;
        it.opcode = op;
        it.operand = opd;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.record_item(i_item);
        op_count[op]++;
        items_sent++;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        burst_left = $urandom_range(1, 8);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        sb = new();
        items_sent = 0;
        fills = 0;
        burst_left = 0;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(OP_ADD, 32'h0000_0000);
        send(OP_BAD6, 32'hffff_ffff);
        send(OP_FINISH, 32'h0000_0000);
        send(OP_PUSH, 32'h7fff_ffff);
        send(OP_PUSH, 32'h7fff_ffff);
        send(OP_ADD, 32'h0000_0000);
        send(OP_PUSH, 32'h8000_0000);
        send(OP_SUB, 32'h0000_0000);
        send(OP_PUSH, 32'h0003_0000);
        send(OP_MUL, 32'h0000_0000);
        send(OP_PUSH, 32'hffff_0000);
        send(OP_MUL, 32'h0000_0000);
        send(OP_PUSH, 32'h0000_8000);
        send(OP_DIV, 32'h0000_0000);
        send(OP_PUSH, 32'h0000_0000);
        send(OP_DIV, 32'h0000_0000);
        send(OP_PUSH, 32'h0005_0000);
        send(OP_PUSH, 32'h0002_0000);
        send(OP_DIV, 32'h0000_0000);
        send(OP_PUSH, 32'hffff_ffff);
        send(OP_PUSH, 32'h0000_8000);
        send(OP_MUL, 32'h0000_0000);
        send(OP_BAD7, 32'h1234_5678);
        send(OP_PUSH, 32'h0001_0000);
        send(OP_FINISH, 32'h0000_0000);
        send(OP_PUSH, 32'h0000_0001);
        send(OP_PUSH, 32'h0000_0002);
        send(OP_FINISH, 32'h0000_0000);
        drain();

        while (items_sent < 925) begin
            kind = $urandom_range(0, 19);
            if (kind >= 18 && fills < 3) begin
                fills++;
                while (sb.entries < STACK_DEPTH) send(OP_PUSH, pick_operand());
                repeat ($urandom_range(1, 3)) send(OP_PUSH, pick_operand());
                repeat ($urandom_range(0, 4))
                    send(3'($urandom_range(OP_ADD, OP_DIV)), pick_operand());
                send(OP_FINISH, pick_operand());
            end else if (kind < 13) begin
                send(OP_PUSH, pick_operand());
                send(OP_PUSH, pick_operand());
                repeat ($urandom_range(1, 12)) begin
                    if (sb.entries < 2 || $urandom_range(0, 2) == 0)
                        send(OP_PUSH, pick_operand());
                    else
                        send(3'($urandom_range(OP_ADD, OP_DIV)), pick_operand());
                end
                while (sb.entries > 1)
                    send(3'($urandom_range(OP_ADD, OP_DIV)), pick_operand());
                send(OP_FINISH, pick_operand());
            end else if (kind < 17) begin
                repeat ($urandom_range(1, 6))
                    send(3'($urandom_range(OP_PUSH, OP_BAD7)), $urandom);
            end else begin
                repeat ($urandom_range(0, 2)) send(OP_PUSH, pick_operand());
                send(3'($urandom_range(OP_ADD, OP_BAD7)), pick_operand());
            end
            if ($urandom_range(0, 24) == 0) drain();
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived.", sb.pending());
            sb.errors += sb.pending();
        end
        $display("Sent %0d items: %0d push, %0d add, %0d sub, %0d mul, %0d div, %0d finish, %0d bad opcode.",
                 items_sent, op_count[OP_PUSH], op_count[OP_ADD], op_count[OP_SUB],
                 op_count[OP_MUL], op_count[OP_DIV], op_count[OP_FINISH],
                 op_count[OP_BAD6] + op_count[OP_BAD7]);
        $display("Checked %0d results, %0d final values, %0d full-stack runs, %0d mismatches.",
                 sb.checked, sb.finals, fills, sb.errors);
        if (sb.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("tb_top: errors");
        $finish;
    end
endmodule
